[sv/polyphase_rational_resampler_top_defines.svh]
// Assertion macros shared by the resampler RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef POLYPHASE_RATIONAL_RESAMPLER_TOP_DEFINES_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRR_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/prr_pkg.sv]
// Shared constants, types and control structs of the polyphase resampler.
// No dependencies; imported by every resampler module.
package prr_pkg;

    // Filter geometry.
    localparam int TAPS_PER_PHASE = 32;
    localparam int MAX_INTERP     = 16;
    localparam int HIST_DEPTH     = 32;
    localparam int COEF_DEPTH     = 512;

    // Field widths.
    localparam int SAMP_W  = 16;
    localparam int COEF_W  = 18;
    localparam int FRAC_W  = 16;
    localparam int OUT_W   = 16;
    localparam int FAC_W   = 5;
    localparam int PH_W    = 6;
    localparam int PH_ST_W = 5;
    localparam int HIST_W  = 2 * SAMP_W;

    // Derived widths.
    localparam int TAP_W   = $clog2(TAPS_PER_PHASE);
    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int COEF_AW = $clog2(COEF_DEPTH);
    localparam int PROD_W  = SAMP_W + COEF_W;
    localparam int ACC_W   = PROD_W + TAP_W;
    localparam int SCL_W   = ACC_W + FAC_W;
    localparam int RND_W   = SCL_W + 1 - FRAC_W;

    // Item kind carried in the input tuser.
    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_COEF   = 1'b1
    } t_kind;

    // Configuration register indexes.
    typedef enum logic {
        REG_INTERP = 1'b0,
        REG_DECI   = 1'b1
    } t_cfg_reg;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TAPS,
        S_DRAIN,
        S_PUSH,
        S_WRAP
    } t_state;

    // Memory requests from the sequencer.
    typedef struct packed {
        logic               coef_we;
        logic               hist_we;
        logic [HIST_AW-1:0] hist_waddr;
        logic               rd_en;
        logic [COEF_AW-1:0] coef_raddr;
        logic [HIST_AW-1:0] hist_raddr;
    } t_mem_ctrl;

    // Datapath control from the sequencer.
    typedef struct packed {
        logic             issue;
        logic             first;
        logic             last;
        logic             push;
        logic             last_run;
        logic [FAC_W-1:0] ni;
    } t_mac_ctrl;

    // Datapath status back to the sequencer.
    typedef struct packed {
        logic done;
        logic out_free;
    } t_mac_stat;

endpackage

[sv/polyphase_rational_resampler_top.sv]
// Polyphase rational resampler for complex 16-bit samples: output rate is the
// input rate times interp/deci. A coefficient transaction (tuser = 1) writes one
// entry of the 512-entry table. A sample transaction (tuser = 0) causes 0 to 16
// outputs and is held longer while a finished output waits on i_m_tready: each
// output passes the phase check, reads 32 taps, one per cycle, from the
// coefficient table and the sample history, then waits for the multiply, gain
// and rounding stages and for the load of the output register. A finished output
// waits in the output register, so the next input is accepted while it is
// still pending. Configuration may be written only while the block is idle.
// Depends on prr_pkg, prr_mem, prr_mac and prr_seq.
module polyphase_rational_resampler_top
    import prr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input stream.
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // [15:0] sample_i, [31:16] sample_q, [40:32] coef_index, [58:41] coef_value, rest zero
    input  logic [63:0]      i_s_tdata,
    // [0] kind
    input  logic             i_s_tuser,
    // Output stream.
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // [15:0] out_i, [31:16] out_q
    output logic [31:0]      o_m_tdata,
    output logic             o_m_tlast,
    // [0] clipped
    output logic             o_m_tuser,
    // Configuration write channel.
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [FAC_W-1:0] i_cfg_data
);

    localparam int CIDX_LO = HIST_W;
    localparam int CVAL_LO = CIDX_LO + COEF_AW;

    t_mem_ctrl                mem_ctrl;
    t_mac_ctrl                mac_ctrl;
    t_mac_stat                mac_stat;
    logic signed [COEF_W-1:0] coef_rdata;
    logic [HIST_W-1:0]        hist_rdata;

    // Control sequencer.
    prr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_kind      (i_s_tuser),
        .o_s_tready  (o_s_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (mac_stat),
        .o_mem       (mem_ctrl),
        .o_mac       (mac_ctrl)
    );

    // Coefficient table and sample history.
    prr_mem u_mem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (mem_ctrl),
        .i_coef_waddr (i_s_tdata[CVAL_LO-1:CIDX_LO]),
        .i_coef_wdata (i_s_tdata[CVAL_LO+COEF_W-1:CVAL_LO]),
        .i_hist_wdata (i_s_tdata[HIST_W-1:0]),
        .o_coef_rdata (coef_rdata),
        .o_hist_rdata (hist_rdata)
    );

    // Multiply-accumulate datapath and output register.
    prr_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (mac_ctrl),
        .i_coef     (coef_rdata),
        .i_hist     (hist_rdata),
        .o_stat     (mac_stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

[sv/prr_mem.sv]
// Coefficient table and circular sample history, both with registered reads.
// Depends on prr_pkg; history entries read as zero until first written.
module prr_mem
    import prr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mem_ctrl                i_ctrl,
    input  logic [COEF_AW-1:0]       i_coef_waddr,
    input  logic signed [COEF_W-1:0] i_coef_wdata,
    input  logic [HIST_W-1:0]        i_hist_wdata,
    output logic signed [COEF_W-1:0] o_coef_rdata,
    output logic [HIST_W-1:0]        o_hist_rdata
);

    logic signed [COEF_W-1:0] r_coef_mem [COEF_DEPTH];
    logic [HIST_W-1:0]        r_hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]    r_hist_valid;
    logic signed [COEF_W-1:0] r_coef_rd;
    logic [HIST_W-1:0]        r_hist_rd;
    logic                     r_hist_rd_vld;

    // Coefficient table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.coef_we) begin
            r_coef_mem[i_coef_waddr] <= i_coef_wdata;
        end
        if (i_ctrl.rd_en) begin
            r_coef_rd <= r_coef_mem[i_ctrl.coef_raddr];
        end
    end

    // Sample history storage with registered read.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.hist_we) begin
            r_hist_mem[i_ctrl.hist_waddr] <= i_hist_wdata;
        end
        if (i_ctrl.rd_en) begin
            r_hist_rd <= r_hist_mem[i_ctrl.hist_raddr];
        end
    end

    // Per-entry written flags, so unwritten history entries read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_valid  <= '0;
            r_hist_rd_vld <= 1'b0;
        end else begin
            if (i_ctrl.hist_we) begin
                r_hist_valid[i_ctrl.hist_waddr] <= 1'b1;
            end
            if (i_ctrl.rd_en) begin
                r_hist_rd_vld <= r_hist_valid[i_ctrl.hist_raddr];
            end
        end
    end

    assign o_coef_rdata = r_coef_rd;
    assign o_hist_rdata = r_hist_rd_vld ? r_hist_rd : '0;

endmodule

[sv/prr_mac.sv]
// Complex multiply-accumulate, gain, rounding, saturation and output register.
// Depends on prr_pkg; fed by prr_mem read data and prr_seq control.
module prr_mac
    import prr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctrl                i_ctrl,
    input  logic signed [COEF_W-1:0] i_coef,
    input  logic [HIST_W-1:0]        i_hist,
    output t_mac_stat                o_stat,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [2*OUT_W-1:0]       o_m_tdata,
    output logic                     o_m_tlast,
    output logic                     o_m_tuser
);

    localparam logic [SCL_W:0] RND_HALF = (SCL_W + 1)'(1) << (FRAC_W - 1);
    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W - 1){1'b0}}};

    // Pipeline control flags.
    logic r_s0_vld, r_s0_first, r_s0_last;
    logic r_s1_vld, r_s1_first, r_s1_last;
    logic r_s2_done, r_s3_done, r_s4_done;

    // Payload stages.
    logic signed [PROD_W-1:0] r_prod_i, r_prod_q;
    logic signed [ACC_W-1:0]  r_acc_i, r_acc_q;
    logic signed [SCL_W-1:0]  r_scl_i, r_scl_q;
    logic [OUT_W-1:0]         r_res_i, r_res_q;
    logic                     r_res_clip;

    // Output register.
    logic                     r_out_vld;
    logic [OUT_W-1:0]         r_out_i, r_out_q;
    logic                     r_out_last, r_out_clip;

    logic signed [SAMP_W-1:0] samp_i, samp_q;
    logic signed [SCL_W-1:0]  acc_ext_i, acc_ext_q, ni_ext;
    logic [SCL_W:0]           rnd_sum_i, rnd_sum_q;
    logic [RND_W-1:0]         rnd_i, rnd_q;
    logic                     ovf_i, ovf_q;

    // True when the rounded value does not fit the output width.
    function automatic logic ovf(input logic [RND_W-1:0] v);
        logic [RND_W-OUT_W:0] top;
        top = v[RND_W-1:OUT_W-1];
        return !((&top) || !(|top));
    endfunction

    // Clamp to the signed output range.
    function automatic logic [OUT_W-1:0] sat(input logic [RND_W-1:0] v, input logic o);
        logic [OUT_W-1:0] res;
        if (o) begin
            res = v[RND_W-1] ? SAT_NEG : SAT_POS;
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

    assign samp_i = i_hist[SAMP_W-1:0];
    assign samp_q = i_hist[HIST_W-1:SAMP_W];

    // Control flags follow the memory read latency and the datapath stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_done <= 1'b0;
            r_s3_done <= 1'b0;
            r_s4_done <= 1'b0;
        end else begin
            r_s0_vld  <= i_ctrl.issue;
            r_s1_vld  <= r_s0_vld;
            r_s2_done <= r_s1_vld && r_s1_last;
            r_s3_done <= r_s2_done;
            r_s4_done <= r_s3_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_first <= i_ctrl.first;
        r_s0_last  <= i_ctrl.last;
        r_s1_first <= r_s0_first;
        r_s1_last  <= r_s0_last;
    end

    // Tap products, one complex pair per cycle.
    always_ff @(posedge i_clk) begin
        if (r_s0_vld) begin
            r_prod_i <= PROD_W'(i_coef) * PROD_W'(samp_i);
            r_prod_q <= PROD_W'(i_coef) * PROD_W'(samp_q);
        end
    end

    // Accumulator, restarted on the first tap of each output.
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            if (r_s1_first) begin
                r_acc_i <= ACC_W'(r_prod_i);
                r_acc_q <= ACC_W'(r_prod_q);
            end else begin
                r_acc_i <= r_acc_i + ACC_W'(r_prod_i);
                r_acc_q <= r_acc_q + ACC_W'(r_prod_q);
            end
        end
    end

    // Gain by the interpolation factor.
    assign acc_ext_i = SCL_W'(r_acc_i);
    assign acc_ext_q = SCL_W'(r_acc_q);
    assign ni_ext    = SCL_W'(i_ctrl.ni);

    always_ff @(posedge i_clk) begin
        if (r_s2_done) begin
            r_scl_i <= acc_ext_i * ni_ext;
            r_scl_q <= acc_ext_q * ni_ext;
        end
    end

    // Round half up from the fractional bits, then saturate.
    assign rnd_sum_i = {r_scl_i[SCL_W-1], r_scl_i} + RND_HALF;
    assign rnd_sum_q = {r_scl_q[SCL_W-1], r_scl_q} + RND_HALF;
    assign rnd_i     = rnd_sum_i[SCL_W:FRAC_W];
    assign rnd_q     = rnd_sum_q[SCL_W:FRAC_W];
    assign ovf_i     = ovf(rnd_i);
    assign ovf_q     = ovf(rnd_q);

    always_ff @(posedge i_clk) begin
        if (r_s3_done) begin
            r_res_i    <= sat(rnd_i, ovf_i);
            r_res_q    <= sat(rnd_q, ovf_q);
            r_res_clip <= ovf_i || ovf_q;
        end
    end

    // Output register, loaded by the sequencer when the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ctrl.push) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_out_i    <= r_res_i;
            r_out_q    <= r_res_q;
            r_out_last <= i_ctrl.last_run;
            r_out_clip <= r_res_clip;
        end
    end

    assign o_stat.done     = r_s4_done;
    assign o_stat.out_free = !r_out_vld || i_m_tready;
    assign o_m_tvalid      = r_out_vld;
    assign o_m_tdata       = {r_out_q, r_out_i};
    assign o_m_tlast       = r_out_last;
    assign o_m_tuser       = r_out_clip;

endmodule

[sv/prr_seq.sv]
// Sequencer: configuration registers, phase bookkeeping and tap address generation.
// Depends on prr_pkg and the assertion macros header; drives prr_mem and prr_mac.
`include "polyphase_rational_resampler_top_defines.svh"

module prr_seq
    import prr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_kind,
    output logic             o_s_tready,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [FAC_W-1:0] i_cfg_data,
    input  t_mac_stat        i_stat,
    output t_mem_ctrl        o_mem,
    output t_mac_ctrl        o_mac
);

    t_state             r_state, n_state;
    logic [FAC_W-1:0]   r_interp_cfg, r_deci_cfg;
    logic [HIST_AW-1:0] r_wptr, r_newest, r_haddr;
    logic [PH_W-1:0]    r_phase, n_phase_step;
    logic [FAC_W-1:0]   r_ni, r_nd, n_ni, n_nd;
    logic [COEF_AW-1:0] r_caddr;
    logic [TAP_W-1:0]   r_tap;
    logic [PH_W-1:0]    phase_wrap;
    logic               in_acc, samp_acc, coef_acc, cfg_acc;
    logic               below, tap_last, push_ok;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign samp_acc    = in_acc && (t_kind'(i_kind) == KIND_SAMPLE);
    assign coef_acc    = in_acc && (t_kind'(i_kind) == KIND_COEF);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    assign below        = (r_phase < PH_W'(r_ni));
    assign tap_last     = (r_tap == TAP_W'(TAPS_PER_PHASE - 1));
    assign push_ok      = (r_state == S_PUSH) && i_stat.out_free;
    assign n_phase_step = r_phase + PH_W'(r_nd);
    assign phase_wrap   = r_phase - PH_W'(r_ni);

    // Effective factors: zero acts as one, interpolation clamps at its maximum.
    always_comb begin
        n_ni = r_interp_cfg;
        if (r_interp_cfg == '0) begin
            n_ni = FAC_W'(1);
        end else if (r_interp_cfg > FAC_W'(MAX_INTERP)) begin
            n_ni = FAC_W'(MAX_INTERP);
        end
        n_nd = (r_deci_cfg == '0) ? FAC_W'(1) : r_deci_cfg;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (samp_acc) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = below ? S_TAPS : S_WRAP;
            S_TAPS: begin
                if (tap_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_stat.out_free) begin
                    n_state = S_CHECK;
                end
            end
            S_WRAP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory and datapath control.
    always_comb begin
        o_mem.coef_we    = coef_acc;
        o_mem.hist_we    = samp_acc;
        o_mem.hist_waddr = r_wptr;
        o_mem.rd_en      = (r_state == S_TAPS);
        o_mem.coef_raddr = r_caddr;
        o_mem.hist_raddr = r_haddr;
        o_mac.issue      = (r_state == S_TAPS);
        o_mac.first      = (r_tap == '0);
        o_mac.last       = tap_last;
        o_mac.push       = push_ok;
        o_mac.last_run   = (n_phase_step >= PH_W'(r_ni));
        o_mac.ni         = r_ni;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_interp_cfg <= FAC_W'(1);
            r_deci_cfg   <= FAC_W'(1);
            r_wptr       <= '0;
            r_phase      <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_INTERP: r_interp_cfg <= i_cfg_data;
                    REG_DECI:   r_deci_cfg   <= i_cfg_data;
                    default:    r_interp_cfg <= r_interp_cfg;
                endcase
            end
            if (samp_acc) begin
                r_wptr <= r_wptr + HIST_AW'(1);
            end
            if (push_ok) begin
                r_phase <= n_phase_step;
            end else if (r_state == S_WRAP) begin
                r_phase <= {1'b0, phase_wrap[PH_ST_W-1:0]};
            end
        end
    end

    // Per-item and per-output working registers.
    always_ff @(posedge i_clk) begin
        if (samp_acc) begin
            r_newest <= r_wptr;
            r_ni     <= n_ni;
            r_nd     <= n_nd;
        end
        if (r_state == S_CHECK) begin
            r_caddr <= COEF_AW'(r_phase);
            r_haddr <= r_newest;
            r_tap   <= '0;
        end else if (r_state == S_TAPS) begin
            r_caddr <= r_caddr + COEF_AW'(r_ni);
            r_haddr <= r_haddr - HIST_AW'(1);
            r_tap   <= r_tap + TAP_W'(1);
        end
    end

    // A finished sum only arrives while the sequencer waits for it.
    `PRR_ASSERT_NOW(a_done_in_drain, i_clk, i_rst_n, i_stat.done, r_state == S_DRAIN, "result completed outside drain")
    // Every emitted output belongs to a phase below the interpolation factor.
    `PRR_ASSERT_NOW(a_push_below, i_clk, i_rst_n, push_ok, below, "output pushed with phase out of range")
    // Between items the stored phase fits in its low PH_ST_W bits.
    `PRR_ASSERT_NOW(a_phase_idle, i_clk, i_rst_n, r_state == S_IDLE, r_phase[PH_W-1] == 1'b0, "idle phase overflow")
    // Each output starts at the newest sample.
    `PRR_ASSERT_NOW(a_first_tap, i_clk, i_rst_n, (r_state == S_TAPS) && (r_tap == '0), r_haddr == r_newest, "first tap not at newest sample")
    // A sample transaction advances the write pointer by exactly one.
    `PRR_ASSERT_NEXT(a_wptr_step, i_clk, i_rst_n, samp_acc, r_wptr == $past(r_wptr) + HIST_AW'(1), "write pointer misstep")

endmodule

[bench/tb.sv]
// Self-checking bench for polyphase_rational_resampler_top: a directed stimulus table and
// a random stream of samples and coefficient writes, checked against an in-bench predictor.
// Depends on prr_pkg and the resampler RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import prr_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_MASK     = (1 << PH_ST_W) - 1;
    localparam int SAT_HI         = 32767;
    localparam int SAT_LO         = -32768;

    // Rate settings of the random part, with the number of transactions for each.
    localparam int NUM_RATES = 10;
    localparam int RATE_INTERP [NUM_RATES] = '{3, 16, 1, 0, 31, 5, 16, 2, 7, 1};
    localparam int RATE_DECI   [NUM_RATES] = '{2, 1, 16, 0, 31, 7, 16, 3, 1, 1};
    localparam int RATE_ITEMS  [NUM_RATES] = '{34, 12, 40, 30, 30, 30, 30, 30, 20, 14};

    typedef struct {
        t_kind                    kind;
        logic signed [SAMP_W-1:0] si;
        logic signed [SAMP_W-1:0] sq;
        logic [COEF_AW-1:0]       cidx;
        logic signed [COEF_W-1:0] cval;
    } rs_item_t;

    typedef struct {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic                    last;
        logic                    clip;
    } iq_out_t;

    typedef struct {
        rs_item_t item;
        bit       typed;
        iq_out_t  want;
    } dir_row_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_HOLD
    } rx_mode_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [63:0]      i_s_tdata;
    logic             i_s_tuser;
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [31:0]      o_m_tdata;
    logic             o_m_tlast;
    logic             o_m_tuser;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic             i_cfg_index;
    logic [FAC_W-1:0] i_cfg_data;

    // Predictor state: history ring, tap table, write pointer, phase and rate registers.
    logic signed [SAMP_W-1:0] hist_re [HIST_DEPTH];
    logic signed [SAMP_W-1:0] hist_im [HIST_DEPTH];
    logic signed [COEF_W-1:0] coef_tab [COEF_DEPTH];
    int                       wr_ptr;
    int                       phase_acc;
    logic [FAC_W-1:0]         cfg_interp;
    logic [FAC_W-1:0]         cfg_deci;

    iq_out_t  fresh_outputs[$];
    iq_out_t  due_outputs[$];
    dir_row_t directed_rows[$];

    int fail_count;
    int quiet_cycles;
    int burst_left;

    polyphase_rational_resampler_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Rounds a Q.16 sum to the nearest integer, halves upward, and saturates to 16 bits.
    function automatic logic signed [OUT_W-1:0] round_q16(input longint acc, inout logic clip);
        longint r;
        r = (acc + 64'sd32768) >>> FRAC_W;
        if (r > SAT_HI) begin
            clip = 1'b1;
            return OUT_W'(SAT_HI);
        end
        if (r < SAT_LO) begin
            clip = 1'b1;
            return OUT_W'(SAT_LO);
        end
        return OUT_W'(r);
    endfunction

    // Applies one input transaction to the predictor and leaves its outputs in fresh_outputs.
    function automatic void run_resampler(input rs_item_t it);
        int      ni;
        int      nd;
        int      newest;
        int      j;
        int      k;
        longint  acc_re;
        longint  acc_im;
        logic    clip;
        iq_out_t r;
        fresh_outputs.delete();
        if (it.kind == KIND_COEF) begin
            coef_tab[it.cidx] = it.cval;
            return;
        end
        ni = int'(cfg_interp);
        if (ni == 0) ni = 1;
        if (ni > MAX_INTERP) ni = MAX_INTERP;
        nd = int'(cfg_deci);
        if (nd == 0) nd = 1;

        newest = wr_ptr;
        hist_re[newest] = it.si;
        hist_im[newest] = it.sq;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;

        // One output per branch while the phase is below the interpolation factor.
        while (phase_acc < ni) begin
            acc_re = 0;
            acc_im = 0;
            j = newest;
            for (k = phase_acc; k < TAPS_PER_PHASE * ni; k += ni) begin
                acc_re += longint'(coef_tab[k % COEF_DEPTH]) * longint'(hist_re[j]);
                acc_im += longint'(coef_tab[k % COEF_DEPTH]) * longint'(hist_im[j]);
                j = (j + HIST_DEPTH - 1) % HIST_DEPTH;
            end
            clip = 1'b0;
            r.re = round_q16(acc_re * ni, clip);
            r.im = round_q16(acc_im * ni, clip);
            r.clip = clip;
            r.last = 1'b0;
            fresh_outputs.push_back(r);
            phase_acc += nd;
        end
        if (fresh_outputs.size() != 0) fresh_outputs[fresh_outputs.size() - 1].last = 1'b1;
        phase_acc = (phase_acc - ni) & PHASE_MASK;
    endfunction

    function automatic void add_row(input t_kind kind, input int si, input int sq,
                                    input int ci, input int cv, input bit typed = 1'b0,
                                    input int ei = 0, input int eq = 0,
                                    input bit el = 1'b0, input bit ec = 1'b0);
        dir_row_t row;
        row.item.kind = kind;
        row.item.si   = SAMP_W'(si);
        row.item.sq   = SAMP_W'(sq);
        row.item.cidx = COEF_AW'(ci);
        row.item.cval = COEF_W'(cv);
        row.typed     = typed;
        row.want.re   = OUT_W'(ei);
        row.want.im   = OUT_W'(eq);
        row.want.last = el;
        row.want.clip = ec;
        directed_rows.push_back(row);
    endfunction

    // Mostly full-scale samples, with the two rails now and then.
    function automatic logic signed [SAMP_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return SAMP_W'(SAT_HI);
            1: return SAMP_W'(SAT_LO);
            default: return SAMP_W'($urandom);
        endcase
    endfunction

    // Mostly small taps so that sums do not always clip, some over the full range.
    function automatic logic signed [COEF_W-1:0] rand_coef();
        if ($urandom_range(0, 7) == 0) return COEF_W'($urandom);
        return COEF_W'(int'($urandom_range(0, 2047)) - 1024);
    endfunction

    // Presents one input transaction, records its predicted outputs, then idles per burst.
    task automatic send_item(input rs_item_t it, input bit typed, input iq_out_t want);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.kind;
        i_s_tdata  <= {5'd0, it.cval, it.cidx, it.sq, it.si};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        run_resampler(it);
        if (typed) due_outputs.push_back(want);
        else foreach (fresh_outputs[n]) due_outputs.push_back(fresh_outputs[n]);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 7);
        end
    endtask

    // Holds the input side until every predicted output has been taken, then settles.
    task automatic wait_drained(input int settle);
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (due_outputs.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Output side stalls on a pattern of its own.
    initial begin : rx_stalls
        rx_mode_t mode;
        int       span;
        i_m_tready <= 1'b0;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = (mode == RX_HOLD) ? $urandom_range(4, 24) : $urandom_range(8, 60);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    RX_OPEN:   i_m_tready <= 1'b1;
                    RX_COIN:   i_m_tready <= ($urandom_range(0, 1) == 1);
                    RX_MOSTLY: i_m_tready <= ($urandom_range(0, 3) != 0);
                    default:   i_m_tready <= 1'b0;
                endcase
            end
        end
    end

    // Compares each output transaction with the oldest predicted output.
    always @(posedge i_clk) begin : check_outputs
        iq_out_t want;
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            if (due_outputs.size() == 0) begin
                $error("output transaction with no result due: tdata %h", o_m_tdata);
                fail_count++;
            end else begin
                want = due_outputs.pop_front();
                if (o_m_tdata[OUT_W-1:0] !== want.re) begin
                    $error("out_i: expected %0d, actual %0d", want.re,
                           $signed(o_m_tdata[OUT_W-1:0]));
                    fail_count++;
                end
                if (o_m_tdata[2*OUT_W-1:OUT_W] !== want.im) begin
                    $error("out_q: expected %0d, actual %0d", want.im,
                           $signed(o_m_tdata[2*OUT_W-1:OUT_W]));
                    fail_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last_of_run: expected %0b, actual %0b", want.last, o_m_tlast);
                    fail_count++;
                end
                if (o_m_tuser !== want.clip) begin
                    $error("clipped: expected %0b, actual %0b", want.clip, o_m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run when no transaction of any kind has happened for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid === 1'b1 && o_s_tready === 1'b1) ||
            (o_m_tvalid === 1'b1 && i_m_tready === 1'b1) ||
            (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        rs_item_t it;
        iq_out_t  none;
        int       p;
        int       n;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= KIND_SAMPLE;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_INTERP;
        i_cfg_data  <= '0;
        fail_count   = 0;
        quiet_cycles = 0;
        burst_left   = 0;
        none         = '{default: '0};

        // Predictor matches the block after reset.
        foreach (hist_re[h]) begin
            hist_re[h] = '0;
            hist_im[h] = '0;
        end
        wr_ptr     = 0;
        phase_acc  = 0;
        cfg_interp = FAC_W'(1);
        cfg_deci   = FAC_W'(1);

        // Directed table at the reset rates (one output per sample). Only the newest
        // tap is set at first, so the typed results follow from the newest sample.
        add_row(KIND_COEF,   0, 0, 0, 65536);
        add_row(KIND_SAMPLE, 0, 0, 0, 0, 1'b1, 0, 0, 1'b1, 1'b0);
        add_row(KIND_SAMPLE, 32767, -32768, 0, 0, 1'b1, 32767, -32768, 1'b1, 1'b0);
        add_row(KIND_SAMPLE, -1, 1, 0, 0, 1'b1, -1, 1, 1'b1, 1'b0);
        // Sample fields of a coefficient write are ignored.
        add_row(KIND_COEF,   -1, -1, 0, 131071);
        add_row(KIND_SAMPLE, 32767, -32768, 0, 0, 1'b1, 32767, -32768, 1'b1, 1'b1);
        add_row(KIND_COEF,   0, 0, 0, -131072);
        add_row(KIND_SAMPLE, 16384, -16384, 0, 0, 1'b1, -32768, 32767, 1'b1, 1'b1);
        // Half a unit rounds up on both signs.
        add_row(KIND_COEF,   0, 0, 0, 32768);
        add_row(KIND_SAMPLE, 1, -1, 0, 0, 1'b1, 1, 0, 1'b1, 1'b0);
        add_row(KIND_COEF,   0, 0, 31, 65536);
        add_row(KIND_COEF,   0, 0, 511, -131072);
        // Coefficient fields of a sample are ignored.
        add_row(KIND_SAMPLE, 1234, -4321, 511, 131071);
        add_row(KIND_COEF,   0, 0, 1, -65536);
        add_row(KIND_SAMPLE, 32767, 32767, 0, 0);
        add_row(KIND_SAMPLE, -32768, -32768, 0, 0);
        add_row(KIND_SAMPLE, -20000, 12345, 0, 0);
        add_row(KIND_SAMPLE, 7, -7, 0, 0);
        add_row(KIND_COEF,   0, 0, 2, 99999);
        add_row(KIND_SAMPLE, -30000, 30000, 0, 0);
        add_row(KIND_SAMPLE, 0, 0, 0, 0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Clear the taps read at unit interpolation before any sample goes in.
        for (n = 0; n < TAPS_PER_PHASE; n++) begin
            it.kind = KIND_COEF;
            it.si   = rand_sample();
            it.sq   = rand_sample();
            it.cidx = COEF_AW'(n);
            it.cval = '0;
            send_item(it, 1'b0, none);
        end

        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

        // Load the whole table so that any interpolation factor reads written taps.
        for (n = 0; n < COEF_DEPTH; n++) begin
            it.kind = KIND_COEF;
            it.si   = rand_sample();
            it.sq   = rand_sample();
            it.cidx = COEF_AW'(n);
            it.cval = rand_coef();
            send_item(it, 1'b0, none);
        end

        // Random traffic under each rate setting; rates change only with the block idle.
        for (p = 0; p < NUM_RATES; p++) begin
            wait_drained(SETTLE_CYCLES);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_INTERP;
            i_cfg_data  <= FAC_W'(RATE_INTERP[p]);
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            cfg_interp = FAC_W'(RATE_INTERP[p]);
            i_cfg_index <= REG_DECI;
            i_cfg_data  <= FAC_W'(RATE_DECI[p]);
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            cfg_deci = FAC_W'(RATE_DECI[p]);
            i_cfg_valid <= 1'b0;

            for (n = 0; n < RATE_ITEMS[p]; n++) begin
                it.kind = ($urandom_range(0, 5) == 0) ? KIND_COEF : KIND_SAMPLE;
                it.si   = rand_sample();
                it.sq   = rand_sample();
                it.cidx = COEF_AW'($urandom_range(0, COEF_DEPTH - 1));
                it.cval = rand_coef();
                send_item(it, 1'b0, none);
                // Now and then the input side waits for the output side to catch up.
                if ($urandom_range(0, 49) == 0) wait_drained(0);
            end
        end

        wait_drained(SETTLE_CYCLES);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
